[hw/rtl/rc4_keystream_cipher_defines.svh]
// Assertion macros for the RC4 keystream cipher block.
// Depends on nothing; modules that use it provide i_clk and i_rst_n.
`ifndef RC4_KEYSTREAM_CIPHER_DEFINES_SVH
`define RC4_KEYSTREAM_CIPHER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define RC4KS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rc4ks: assertion failed");
// Next-cycle implication, checked outside reset
`define RC4KS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rc4ks: assertion failed");
`else
`define RC4KS_ASSERT_IMP(lbl, ante, cons)
`define RC4KS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/rc4ks_pkg.sv]
// Shared constants, codes and controller/datapath types of the RC4 cipher.
// Depends on nothing.
package rc4ks_pkg;

    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_WORDS   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int KEY_LEN_W   = 6;
    localparam int KEY_POS_W   = 5;
    localparam int DROP_W      = 16;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MIN   = KEY_LEN_W'(5);
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(32);
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);
    localparam logic [ADDR_W-1:0]    LAST_ENTRY    = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [BYTE_W-1:0]    BYTE_MASK     = BYTE_W'(8'hFF);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0     = 3'd0,
        CFG_KEY1     = 3'd1,
        CFG_KEY2     = 3'd2,
        CFG_KEY3     = 3'd3,
        CFG_KEY_LEN  = 3'd4,
        CFG_DROP     = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_CLEAR,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_DROP_INIT,
        ST_PR_RD_I,
        ST_PR_RD_J,
        ST_PR_WR_I,
        ST_PR_WR_J,
        ST_RESULT
    } t_state;

    // Datapath micro-operations on the permutation and indices
    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_KS_CLEAR,
        UOP_KS_RD_N,
        UOP_KS_RD_J,
        UOP_KS_WR_N,
        UOP_KS_WR_J,
        UOP_DROP_INIT,
        UOP_PR_RD_I,
        UOP_PR_RD_J,
        UOP_PR_WR_I,
        UOP_PR_WR_J
    } t_uop;

    typedef struct packed {
        logic capture;
        logic load_out;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic key_ok;
        logic is_init;
        logic ks_last;
        logic drop_zero;
        logic drop_last;
    } t_dp_status;

endpackage

[hw/rtl/rc4ks_in_if.sv]
// Request channel into the RC4 cipher: item kind and data byte.
// Depends on rc4ks_pkg.
interface rc4ks_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [rc4ks_pkg::BYTE_W-1:0]   data_in;

    modport source (output valid, output kind, output data_in, input ready);
    modport sink   (input valid, input kind, input data_in, output ready);
endinterface

[hw/rtl/rc4ks_out_if.sv]
// Result channel out of the RC4 cipher: data byte and initialise status.
// Depends on rc4ks_pkg.
interface rc4ks_out_if;
    logic                           valid;
    logic                           ready;
    logic [rc4ks_pkg::BYTE_W-1:0]   data_out;
    logic                           init_done;
    logic                           key_rejected;

    modport source (output valid, output data_out, output init_done,
                    output key_rejected, input ready);
    modport sink   (input valid, input data_out, input init_done,
                    input key_rejected, output ready);
endinterface

[hw/rtl/rc4ks_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rc4ks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rc4ks_dp.sv]
// RC4 datapath: configuration registers, permutation RAM with per-entry
// valid flags, indices, key schedule and keystream arithmetic, result register.
// Depends on rc4ks_pkg and rc4ks_ram.
module rc4ks_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rc4ks_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rc4ks_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_kind,
    input  logic [rc4ks_pkg::BYTE_W-1:0]        i_in_data,
    input  rc4ks_pkg::t_dp_cmd                  i_cmd,
    output rc4ks_pkg::t_dp_status               o_status,
    output logic [rc4ks_pkg::BYTE_W-1:0]        o_data_out,
    output logic                                o_init_done,
    output logic                                o_key_rejected
);

    // Configuration
    logic [rc4ks_pkg::CFG_DATA_W-1:0]   r_key [rc4ks_pkg::KEY_WORDS];
    logic [rc4ks_pkg::KEY_LEN_W-1:0]    r_key_len;
    logic [rc4ks_pkg::DROP_W-1:0]       r_drop_count;

    // Captured request
    logic                               r_kind;
    logic                               r_reject;
    logic [rc4ks_pkg::BYTE_W-1:0]       r_data_in;

    // Permutation read side
    logic [rc4ks_pkg::TABLE_DEPTH-1:0]  r_valid;
    logic [rc4ks_pkg::ADDR_W-1:0]       r_rd_addr;
    logic                               r_rd_vld;
    logic [rc4ks_pkg::BYTE_W-1:0]       w_ram_q;
    logic [rc4ks_pkg::BYTE_W-1:0]       w_rd_word;

    // Indices and working values
    logic [rc4ks_pkg::ADDR_W-1:0]       r_i;
    logic [rc4ks_pkg::ADDR_W-1:0]       r_j;
    logic [rc4ks_pkg::ADDR_W-1:0]       r_n;
    logic [rc4ks_pkg::KEY_POS_W-1:0]    r_pos;
    logic [rc4ks_pkg::BYTE_W-1:0]       r_a;
    logic [rc4ks_pkg::BYTE_W-1:0]       r_b;
    logic                               r_hit_i;
    logic                               r_hit_j;
    logic [rc4ks_pkg::BYTE_W-1:0]       r_ks;
    logic [rc4ks_pkg::DROP_W-1:0]       r_drop_left;

    // Result register
    logic [rc4ks_pkg::BYTE_W-1:0]       r_data_out;
    logic                               r_init_done;
    logic                               r_key_rejected;

    logic                               w_key_ok;
    logic [rc4ks_pkg::BYTE_W-1:0]       w_key_byte;
    logic [rc4ks_pkg::KEY_LEN_W-1:0]    w_pos_inc;
    logic [rc4ks_pkg::ADDR_W-1:0]       w_i_next;
    logic [rc4ks_pkg::ADDR_W-1:0]       w_j_ks;
    logic [rc4ks_pkg::ADDR_W-1:0]       w_j_pr;
    logic [rc4ks_pkg::ADDR_W-1:0]       w_t;
    logic [rc4ks_pkg::BYTE_W-1:0]       w_ks;
    logic                               w_we;
    logic [rc4ks_pkg::ADDR_W-1:0]       w_waddr;
    logic [rc4ks_pkg::BYTE_W-1:0]       w_wdata;
    logic [rc4ks_pkg::ADDR_W-1:0]       w_raddr;

    rc4ks_ram #(
        .WIDTH (rc4ks_pkg::BYTE_W),
        .DEPTH (rc4ks_pkg::TABLE_DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // Entry never written since the last clear reads as its own index
    assign w_rd_word = r_rd_vld ? w_ram_q : r_rd_addr;

    assign w_key_ok   = (r_key_len >= rc4ks_pkg::KEY_LEN_MIN)
                     && (r_key_len <= rc4ks_pkg::KEY_LEN_MAX);
    assign w_key_byte = r_key[r_pos[4:3]][{r_pos[2:0], 3'b000} +: rc4ks_pkg::BYTE_W];
    assign w_pos_inc  = {1'b0, r_pos} + rc4ks_pkg::KEY_LEN_W'(1);
    assign w_i_next   = r_i + rc4ks_pkg::ADDR_W'(1);
    assign w_j_ks     = r_j + w_rd_word + w_key_byte;
    assign w_j_pr     = r_j + w_rd_word;
    assign w_t        = r_a + w_rd_word;

    // Keystream byte, bypassing the two entries swapped this round
    assign w_ks = r_hit_i ? r_b : (r_hit_j ? r_a : w_rd_word);

    // Drive the RAM ports from the micro-operation
    always_comb begin
        w_raddr = r_n;
        w_we    = 1'b0;
        w_waddr = r_i;
        w_wdata = w_rd_word;
        case (i_cmd.uop)
            rc4ks_pkg::UOP_KS_RD_N: begin
                w_raddr = r_n;
            end
            rc4ks_pkg::UOP_KS_RD_J: begin
                w_raddr = w_j_ks;
            end
            rc4ks_pkg::UOP_KS_WR_N: begin
                w_we    = 1'b1;
                w_waddr = r_n;
                w_wdata = w_rd_word;
            end
            rc4ks_pkg::UOP_KS_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_a;
            end
            rc4ks_pkg::UOP_PR_RD_I: begin
                w_raddr = w_i_next;
            end
            rc4ks_pkg::UOP_PR_RD_J: begin
                w_raddr = w_j_pr;
            end
            rc4ks_pkg::UOP_PR_WR_I: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rd_word;
                w_raddr = w_t;
            end
            rc4ks_pkg::UOP_PR_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_a;
            end
            default: begin
            end
        endcase
    end

    // Control state: configuration, valid flags, indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rc4ks_pkg::KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
            r_key_len    <= rc4ks_pkg::KEY_LEN_RESET;
            r_drop_count <= '0;
            r_valid      <= '0;
            r_i          <= '0;
            r_j          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx) inside
                    rc4ks_pkg::CFG_KEY0, rc4ks_pkg::CFG_KEY1,
                    rc4ks_pkg::CFG_KEY2, rc4ks_pkg::CFG_KEY3: begin
                        r_key[i_cfg_idx[1:0]] <= i_cfg_data;
                    end
                    rc4ks_pkg::CFG_KEY_LEN: begin
                        r_key_len <= i_cfg_data[rc4ks_pkg::KEY_LEN_W-1:0];
                    end
                    rc4ks_pkg::CFG_DROP: begin
                        r_drop_count <= i_cfg_data[rc4ks_pkg::DROP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // Mark written entries; a new key schedule starts from identity
            if (i_cmd.uop == rc4ks_pkg::UOP_KS_CLEAR) begin
                r_valid <= '0;
            end else if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end

            case (i_cmd.uop)
                rc4ks_pkg::UOP_KS_CLEAR:  r_j <= '0;
                rc4ks_pkg::UOP_KS_RD_J:   r_j <= w_j_ks;
                rc4ks_pkg::UOP_DROP_INIT: begin
                    r_i <= '0;
                    r_j <= '0;
                end
                rc4ks_pkg::UOP_PR_RD_I:   r_i <= w_i_next;
                rc4ks_pkg::UOP_PR_RD_J:   r_j <= w_j_pr;
                default: begin
                end
            endcase
        end
    end

    // Working values, captured request and result
    always_ff @(posedge i_clk) begin
        r_rd_addr <= w_raddr;
        r_rd_vld  <= r_valid[w_raddr];

        if (i_cmd.capture) begin
            r_kind    <= i_in_kind;
            r_data_in <= i_in_data;
            r_reject  <= i_in_kind & ~w_key_ok;
        end

        case (i_cmd.uop)
            rc4ks_pkg::UOP_KS_CLEAR: begin
                r_n   <= '0;
                r_pos <= '0;
            end
            rc4ks_pkg::UOP_KS_RD_J: begin
                r_a <= w_rd_word;
            end
            rc4ks_pkg::UOP_KS_WR_J: begin
                r_n <= r_n + rc4ks_pkg::ADDR_W'(1);
                if (w_pos_inc >= r_key_len) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= w_pos_inc[rc4ks_pkg::KEY_POS_W-1:0];
                end
            end
            rc4ks_pkg::UOP_DROP_INIT: begin
                r_drop_left <= r_drop_count;
            end
            rc4ks_pkg::UOP_PR_RD_J: begin
                r_a <= w_rd_word;
            end
            rc4ks_pkg::UOP_PR_WR_I: begin
                r_b     <= w_rd_word;
                r_hit_i <= (w_t == r_i);
                r_hit_j <= (w_t == r_j);
            end
            rc4ks_pkg::UOP_PR_WR_J: begin
                r_ks        <= w_ks;
                r_drop_left <= r_drop_left - rc4ks_pkg::DROP_W'(1);
            end
            default: begin
            end
        endcase

        if (i_cmd.load_out) begin
            r_data_out     <= r_kind ? '0 : ((r_data_in ^ r_ks) & rc4ks_pkg::BYTE_MASK);
            r_init_done    <= r_kind;
            r_key_rejected <= r_reject;
        end
    end

    assign o_status.key_ok    = w_key_ok;
    assign o_status.is_init   = r_kind;
    assign o_status.ks_last   = (r_n == rc4ks_pkg::LAST_ENTRY);
    assign o_status.drop_zero = (r_drop_count == '0);
    assign o_status.drop_last = (r_drop_left == rc4ks_pkg::DROP_W'(1));

    assign o_data_out     = r_data_out;
    assign o_init_done    = r_init_done;
    assign o_key_rejected = r_key_rejected;

endmodule

[hw/rtl/rc4ks_ctrl.sv]
// RC4 controller: sequences key schedule, drop rounds and keystream rounds,
// owns the request/result handshakes. Depends on rc4ks_pkg and the defines.
`include "rc4_keystream_cipher_defines.svh"

module rc4ks_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_kind,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  rc4ks_pkg::t_dp_status       i_status,
    output rc4ks_pkg::t_dp_cmd          o_cmd
);

    rc4ks_pkg::t_state r_state;
    rc4ks_pkg::t_state n_state;
    logic              r_out_valid;
    logic              w_accept;
    logic              w_out_free;

    assign o_in_ready  = (r_state == rc4ks_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rc4ks_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (!i_in_kind) begin
                        n_state = rc4ks_pkg::ST_PR_RD_I;
                    end else if (i_status.key_ok) begin
                        n_state = rc4ks_pkg::ST_KS_CLEAR;
                    end else begin
                        n_state = rc4ks_pkg::ST_RESULT;
                    end
                end
            end
            rc4ks_pkg::ST_KS_CLEAR: n_state = rc4ks_pkg::ST_KS_RD_N;
            rc4ks_pkg::ST_KS_RD_N:  n_state = rc4ks_pkg::ST_KS_RD_J;
            rc4ks_pkg::ST_KS_RD_J:  n_state = rc4ks_pkg::ST_KS_WR_N;
            rc4ks_pkg::ST_KS_WR_N:  n_state = rc4ks_pkg::ST_KS_WR_J;
            rc4ks_pkg::ST_KS_WR_J: begin
                n_state = i_status.ks_last ? rc4ks_pkg::ST_DROP_INIT
                                           : rc4ks_pkg::ST_KS_RD_N;
            end
            rc4ks_pkg::ST_DROP_INIT: begin
                n_state = i_status.drop_zero ? rc4ks_pkg::ST_RESULT
                                             : rc4ks_pkg::ST_PR_RD_I;
            end
            rc4ks_pkg::ST_PR_RD_I:  n_state = rc4ks_pkg::ST_PR_RD_J;
            rc4ks_pkg::ST_PR_RD_J:  n_state = rc4ks_pkg::ST_PR_WR_I;
            rc4ks_pkg::ST_PR_WR_I:  n_state = rc4ks_pkg::ST_PR_WR_J;
            rc4ks_pkg::ST_PR_WR_J: begin
                // Drop rounds loop until the last one; a data round ends here
                if (i_status.is_init && !i_status.drop_last) begin
                    n_state = rc4ks_pkg::ST_PR_RD_I;
                end else begin
                    n_state = rc4ks_pkg::ST_RESULT;
                end
            end
            rc4ks_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_state = rc4ks_pkg::ST_IDLE;
                end
            end
            default: n_state = rc4ks_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd.capture  = w_accept;
        o_cmd.load_out = 1'b0;
        o_cmd.uop      = rc4ks_pkg::UOP_NONE;
        unique case (r_state)
            rc4ks_pkg::ST_IDLE:      o_cmd.uop = rc4ks_pkg::UOP_NONE;
            rc4ks_pkg::ST_KS_CLEAR:  o_cmd.uop = rc4ks_pkg::UOP_KS_CLEAR;
            rc4ks_pkg::ST_KS_RD_N:   o_cmd.uop = rc4ks_pkg::UOP_KS_RD_N;
            rc4ks_pkg::ST_KS_RD_J:   o_cmd.uop = rc4ks_pkg::UOP_KS_RD_J;
            rc4ks_pkg::ST_KS_WR_N:   o_cmd.uop = rc4ks_pkg::UOP_KS_WR_N;
            rc4ks_pkg::ST_KS_WR_J:   o_cmd.uop = rc4ks_pkg::UOP_KS_WR_J;
            rc4ks_pkg::ST_DROP_INIT: o_cmd.uop = rc4ks_pkg::UOP_DROP_INIT;
            rc4ks_pkg::ST_PR_RD_I:   o_cmd.uop = rc4ks_pkg::UOP_PR_RD_I;
            rc4ks_pkg::ST_PR_RD_J:   o_cmd.uop = rc4ks_pkg::UOP_PR_RD_J;
            rc4ks_pkg::ST_PR_WR_I:   o_cmd.uop = rc4ks_pkg::UOP_PR_WR_I;
            rc4ks_pkg::ST_PR_WR_J:   o_cmd.uop = rc4ks_pkg::UOP_PR_WR_J;
            rc4ks_pkg::ST_RESULT:    o_cmd.load_out = w_out_free;
            default:                 o_cmd.uop = rc4ks_pkg::UOP_NONE;
        endcase
    end

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc4ks_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `RC4KS_ASSERT_NXT(a_data_starts_round, w_accept && !i_in_kind, r_state == rc4ks_pkg::ST_PR_RD_I)
    `RC4KS_ASSERT_NXT(a_bad_key_answers, w_accept && i_in_kind && !i_status.key_ok, r_state == rc4ks_pkg::ST_RESULT)
    `RC4KS_ASSERT_NXT(a_schedule_ends, r_state == rc4ks_pkg::ST_KS_WR_J && i_status.ks_last, r_state == rc4ks_pkg::ST_DROP_INIT)
    `RC4KS_ASSERT_NXT(a_load_shows_result, o_cmd.load_out, r_out_valid && r_state == rc4ks_pkg::ST_IDLE)

endmodule

[hw/rtl/rc4_keystream_cipher.sv]
// RC4-drop[N] cipher. Data byte: a taken request steps through PR_RD_I, PR_RD_J, PR_WR_I
// and PR_WR_J, then RESULT registers the result; the next request is taken only back in
// IDLE. Initialise: KS_CLEAR, then KS_RD_N, KS_RD_J, KS_WR_N and KS_WR_J per table entry,
// DROP_INIT and drop_count drop rounds; a rejected key goes straight to RESULT. Synchronous
// active-low reset restores the configuration registers, indices and controller state;
// the permutation reads as identity through per-entry valid flags.
module rc4_keystream_cipher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rc4ks_in_if.sink                            i_in,
    rc4ks_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [rc4ks_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rc4ks_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    rc4ks_pkg::t_dp_cmd     w_cmd;
    rc4ks_pkg::t_dp_status  w_status;

    rc4ks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rc4ks_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_kind      (i_in.kind),
        .i_in_data      (i_in.data_in),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_data_out     (o_out.data_out),
        .o_init_done    (o_out.init_done),
        .o_key_rejected (o_out.key_rejected)
    );

endmodule

[test/rc4ks_tb_pkg.sv]
`timescale 1ns / 1ps
// Request kinds and spare register indexes shared by the RC4 cipher bench.
// Depends on rc4ks_pkg for the register index width.
package rc4ks_tb_pkg;

    import rc4ks_pkg::*;

    // Kind field of a request
    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_INIT = 1'b1
    } req_kind_e;

    // Register indexes past the end of the register list; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(7);

endpackage

[test/rc4ks_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the RC4 cipher: mirrors the key registers, keeps its own
// permutation and indices, and checks each result. Depends on rc4ks_pkg,
// rc4ks_tb_pkg and the two channel interfaces.
module rc4ks_checker
    import rc4ks_pkg::*, rc4ks_tb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    rc4ks_in_if                     i_req,
    rc4ks_out_if                    i_res,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_errors,
    output int                      o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              init_done;
        logic              key_rejected;
    } cipher_result_t;

    // Mirror of the key registers
    logic [CFG_DATA_W-1:0] key_word [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  key_len;
    logic [DROP_W-1:0]     drop_len;

    // Own copy of the cipher state
    logic [BYTE_W-1:0]     sbox [TABLE_DEPTH];
    logic [BYTE_W-1:0]     ptr_i;
    logic [BYTE_W-1:0]     ptr_j;

    cipher_result_t        awaited_q [$];
    int                    mismatch_count = 0;
    int                    backlog = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = backlog;

    // Advance i and j, swap, and return the next keystream byte
    function automatic logic [BYTE_W-1:0] keystream_next();
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] ks_addr;
        ptr_i = ptr_i + 1'b1;
        a = sbox[ptr_i];
        ptr_j = ptr_j + a;
        b = sbox[ptr_j];
        sbox[ptr_i] = b;
        sbox[ptr_j] = a;
        ks_addr = a + b;
        return sbox[ks_addr];
    endfunction

    // Key schedule from the identity, clear both indices, then discard the drop bytes
    function automatic void schedule_key();
        int                n;
        int                pos;
        logic [BYTE_W-1:0] jj;
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] kb;
        for (n = 0; n < TABLE_DEPTH; n++)
            sbox[n] = BYTE_W'(n);
        jj  = '0;
        pos = 0;
        for (n = 0; n < TABLE_DEPTH; n++) begin
            t  = sbox[n];
            kb = key_word[pos / 8][(pos % 8) * 8 +: 8];
            jj = jj + t + kb;
            sbox[n]  = sbox[jj];
            sbox[jj] = t;
            pos++;
            if (pos >= key_len)
                pos = 0;
        end
        ptr_i = '0;
        ptr_j = '0;
        for (n = 0; n < drop_len; n++)
            void'(keystream_next());
    endfunction

    // Work out the result of one request and update the state
    function automatic cipher_result_t predict_result(logic kind, logic [BYTE_W-1:0] din);
        cipher_result_t r;
        r = '0;
        if (kind == KIND_INIT) begin
            r.init_done = 1'b1;
            if (key_len < KEY_LEN_MIN || key_len > KEY_LEN_MAX)
                r.key_rejected = 1'b1;
            else
                schedule_key();
        end else begin
            r.data_out = din ^ keystream_next();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cipher_result_t want;
        cipher_result_t got;
        if (!i_rst_n) begin
            // Restore register and state reset values
            for (int k = 0; k < KEY_WORDS; k++)
                key_word[k] = '0;
            key_len  = KEY_LEN_RESET;
            drop_len = '0;
            for (int k = 0; k < TABLE_DEPTH; k++)
                sbox[k] = BYTE_W'(k);
            ptr_i = '0;
            ptr_j = '0;
            awaited_q.delete();
            backlog <= 0;
        end else begin
            // Mirror register writes; spare indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY0:    key_word[0] = i_cfg_data;
                    CFG_KEY1:    key_word[1] = i_cfg_data;
                    CFG_KEY2:    key_word[2] = i_cfg_data;
                    CFG_KEY3:    key_word[3] = i_cfg_data;
                    CFG_KEY_LEN: key_len     = i_cfg_data[KEY_LEN_W-1:0];
                    CFG_DROP:    drop_len    = i_cfg_data[DROP_W-1:0];
                    default: ;
                endcase
            end

            // Predict on every accepted request
            if (i_req.valid && i_req.ready)
                awaited_q.push_back(predict_result(i_req.kind, i_req.data_in));

            // Compare every accepted result with the oldest prediction
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.data_out, i_res.init_done, i_res.key_rejected};
                if (awaited_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, actual %02h/%0b/%0b",
                             $time, got.data_out, got.init_done, got.key_rejected);
                end else begin
                    want = awaited_q.pop_front();
                    if (got.data_out !== want.data_out) begin
                        mismatch_count++;
                        $display("%0t: data_out expected %02h actual %02h",
                                 $time, want.data_out, got.data_out);
                    end
                    if (got.init_done !== want.init_done) begin
                        mismatch_count++;
                        $display("%0t: init_done expected %0b actual %0b",
                                 $time, want.init_done, got.init_done);
                    end
                    if (got.key_rejected !== want.key_rejected) begin
                        mismatch_count++;
                        $display("%0t: key_rejected expected %0b actual %0b",
                                 $time, want.key_rejected, got.key_rejected);
                    end
                end
            end
            backlog <= awaited_q.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Top of the RC4 cipher bench: clock, reset, key settings, requests and verdict.
// Depends on rc4ks_pkg, rc4ks_tb_pkg, the channel interfaces and rc4ks_checker.
module tb;

    import rc4ks_pkg::*;
    import rc4ks_tb_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int PLAN_ITEMS   = RANDOM_ITEMS + 21;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 800_000;
    localparam int HOLD_SESSION = 3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   hold_start;

    int send_idle_pct = 36;
    int recv_idle_pct = 79;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int items_sent    = 0;
    int mismatches;
    int backlog;

    rc4ks_in_if  req_ch ();
    rc4ks_out_if res_ch ();

    rc4_keystream_cipher DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rc4ks_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (mismatches),
        .o_pending  (backlog)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left    <= LONG_HOLD;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[rc4_keystream_cipher] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, idling first at the current rate, and hold until taken
    task automatic offer(input req_kind_e kind, input logic [BYTE_W-1:0] din);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= kind;
        req_ch.data_in <= din;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        items_sent++;
        // Swap the idling rates at one third, stop idling at two thirds
        if (items_sent >= 2 * PLAN_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end else if (items_sent >= PLAN_ITEMS / 3) begin
            send_idle_pct = 79;
            recv_idle_pct = 36;
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (backlog != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Load a full key setting once the block is idle; spare indexes get junk
    task automatic load_key(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                            input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3,
                            input logic [KEY_LEN_W-1:0] len, input logic [DROP_W-1:0] drop);
        settle();
        write_reg(CFG_SPARE_A, {$urandom(), $urandom()});
        write_reg(CFG_SPARE_B, {$urandom(), $urandom()});
        write_reg(CFG_KEY0, w0);
        write_reg(CFG_KEY1, w1);
        write_reg(CFG_KEY2, w2);
        write_reg(CFG_KEY3, w3);
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(len));
        write_reg(CFG_DROP, CFG_DATA_W'(drop));
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [KEY_LEN_W-1:0] len;
        logic [DROP_W-1:0]    drop;
        int                   nbytes;
        int                   session;

        req_ch.valid   <= 1'b0;
        req_ch.kind    <= KIND_DATA;
        req_ch.data_in <= '0;
        cfg_we         <= 1'b0;
        cfg_idx        <= '0;
        cfg_data       <= '0;
        hold_start     <= 1'b0;
        i_rst_n        <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Data before any key runs on the identity permutation
        offer(KIND_DATA, 8'h00);
        offer(KIND_DATA, 8'hFF);
        offer(KIND_DATA, 8'h5A);
        offer(KIND_DATA, 8'hA5);
        // Initialise with the reset key setting
        offer(KIND_INIT, 8'hFF);
        offer(KIND_DATA, 8'h00);
        offer(KIND_DATA, 8'hFF);

        // Key lengths out of range are refused and leave the state alone
        load_key('1, '1, '1, '1, KEY_LEN_W'(4), '0);
        offer(KIND_INIT, 8'h00);
        offer(KIND_DATA, 8'h3C);
        load_key('1, '1, '1, '1, '0, '0);
        offer(KIND_INIT, 8'h00);
        load_key('1, '1, '1, '1, KEY_LEN_W'(33), '1);
        offer(KIND_INIT, 8'h00);
        load_key('1, '1, '1, '1, '1, '1);
        offer(KIND_INIT, 8'h00);

        // Longest key, all ones
        load_key('1, '1, '1, '1, KEY_LEN_MAX, '0);
        offer(KIND_INIT, 8'h00);
        offer(KIND_DATA, 8'h00);
        offer(KIND_DATA, 8'hFF);

        // Shortest key; bytes past the length carry junk that must be ignored
        load_key({$urandom(), $urandom()}, {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, {$urandom(), $urandom()}, KEY_LEN_MIN, '0);
        offer(KIND_INIT, 8'h00);
        offer(KIND_DATA, 8'h81);
        offer(KIND_DATA, 8'h7E);

        // Largest drop count with an all-zero key
        load_key('0, '0, '0, '0, KEY_LEN_MIN, '1);
        offer(KIND_INIT, 8'h00);
        offer(KIND_DATA, 8'hFF);
        offer(KIND_DATA, 8'h00);

        // Random sessions: new key setting, initialise, then a run of data bytes with occasional initialise requests
        session = 0;
        while (items_sent < PLAN_ITEMS) begin
            if ($urandom_range(99) < 80)
                len = KEY_LEN_W'($urandom_range(KEY_LEN_MIN, KEY_LEN_MAX));
            else
                len = KEY_LEN_W'($urandom_range(0, 63));
            case ($urandom_range(19))
                0:       drop = DROP_W'($urandom_range(601, 3000));
                1, 2, 3,
                4, 5:    drop = DROP_W'($urandom_range(41, 600));
                default: drop = DROP_W'($urandom_range(0, 40));
            endcase
            load_key({$urandom(), $urandom()}, {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, {$urandom(), $urandom()}, len, drop);
            offer(KIND_INIT, BYTE_W'($urandom_range(255)));

            // Once, hold the result side off while requests keep coming
            if (session == HOLD_SESSION)
                hold_start <= 1'b1;
            nbytes = $urandom_range(10, 60);
            for (int k = 0; k < nbytes; k++) begin
                if ($urandom_range(99) < 4)
                    offer(KIND_INIT, BYTE_W'($urandom_range(255)));
                else
                    offer(KIND_DATA, BYTE_W'($urandom_range(255)));
                hold_start <= 1'b0;
            end
            session++;
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && backlog == 0) begin
            $display("[rc4_keystream_cipher] OK");
        end else begin
            $display("[rc4_keystream_cipher] ERROR");
        end
        $finish;
    end

endmodule
